FILE: rtl/dfrt_pkg.sv
// Package: constants, types and codes for the dedup fingerprint refcount table.
package dfrt_pkg;

  localparam int NUM_BUCKETS = 1024;
  localparam int BUCKET_WAYS = 4;
  localparam int LOG_ENTRIES = 4096;
  localparam int OFFSET_BITS = 40;
  localparam int SIZE_BITS   = 20;

  localparam int FUNC_W   = 2;
  localparam int FP_W     = 64;
  localparam int CSIZE_W  = 20;
  localparam int STATUS_W = 4;
  localparam int REF_W    = 16;
  localparam int NBYTES_W = 4;

  localparam int SLOT_W   = $clog2(LOG_ENTRIES);
  localparam int FH_W     = $clog2(LOG_ENTRIES + 1);
  localparam int BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int WAYF_W   = SLOT_W + FP_W;
  localparam int ROW_W    = BUCKET_WAYS * WAYF_W;
  localparam int ENT_W    = OFFSET_BITS + SIZE_BITS + REF_W;
  localparam int SUM_W    = ((OFFSET_BITS > CSIZE_W) ? OFFSET_BITS : CSIZE_W) + 1;
  localparam int CLR_DEPTH = (NUM_BUCKETS > LOG_ENTRIES) ? NUM_BUCKETS : LOG_ENTRIES;
  localparam int CLR_W    = $clog2(CLR_DEPTH);

  localparam logic [REF_W-1:0]    REF_MAX = '1;
  localparam logic [NBYTES_W-1:0] NBYTES_RESET = NBYTES_W'(6);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 4'd0,
    ST_DUP       = 4'd1,
    ST_FOUND     = 4'd2,
    ST_NOT_FOUND = 4'd3,
    ST_FREED     = 4'd4,
    ST_DECR      = 4'd5,
    ST_BKT_FULL  = 4'd6,
    ST_LOG_FULL  = 4'd7,
    ST_NO_SPACE  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BKT,
    S_ENT
  } state_t;

endpackage

FILE: rtl/dedup_fingerprint_refcount_table.sv
// Top level: deduplication fingerprint index with reference counts.
//
// Input channel in_*: one transaction carries func, fingerprint and chunk
// size. Result channel out_*: one transaction per input with status, log
// slot, data offset, stored size and refcount. Both use valid/stall.
// Config channel cfg_*: valid/ready write of fingerprint_bytes (reset 6).
//
// Each transaction passes a bucket row read, an entry and free-list read,
// then decide and write back with one shared adder. The block takes one
// transaction at a time and accepts the next only when the write-back is
// done; the result is registered at the write-back.
//
// After reset a clearing pass over max(NUM_BUCKETS, LOG_ENTRIES) = 4096
// addresses empties the bucket memory and links the free list; in_stall is
// high during it. Config writes are taken at any time.
//
// The result sits in an output register; while out_stall holds it, the
// block takes one more transaction, carries it up to the write-back and
// holds it there with in_stall high.
module dedup_fingerprint_refcount_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dfrt_pkg::FUNC_W-1:0]        in_func,
  input  logic [dfrt_pkg::FP_W-1:0]          in_fingerprint,
  input  logic [dfrt_pkg::CSIZE_W-1:0]       in_chunk_size,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dfrt_pkg::STATUS_W-1:0]      out_status,
  output logic [dfrt_pkg::SLOT_W-1:0]        out_log_slot,
  output logic [dfrt_pkg::OFFSET_BITS-1:0]   out_data_offset,
  output logic [dfrt_pkg::SIZE_BITS-1:0]     out_stored_size,
  output logic [dfrt_pkg::REF_W-1:0]         out_refcnt,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dfrt_pkg::NBYTES_W-1:0]      cfg_fingerprint_bytes
);
  import dfrt_pkg::*;

  localparam logic [SLOT_W:0] LE_CMP = (SLOT_W + 1)'(LOG_ENTRIES);
  localparam logic [FH_W-1:0] FH_LIM = FH_W'(LOG_ENTRIES);
  localparam logic [CLR_W:0]  NB_CMP = (CLR_W + 1)'(NUM_BUCKETS);
  localparam logic [CLR_W:0]  LE_CLR = (CLR_W + 1)'(LOG_ENTRIES);

  state_t state_r, state_nxt;
  logic [CLR_W-1:0]       clr_r, clr_nxt;
  logic [NBYTES_W-1:0]    nbytes_r;
  logic [FH_W-1:0]        free_head_r, free_head_nxt;
  logic [OFFSET_BITS-1:0] next_off_r, next_off_nxt;
  logic [FUNC_W-1:0]      func_r;
  logic [FP_W-1:0]        key_r, mask_r;
  logic [CSIZE_W-1:0]     csize_r;
  logic [BKT_W-1:0]       bkt_r;
  logic                   hit_r, emp_r;
  logic [WAY_W-1:0]       hit_way_r, emp_way_r;
  logic [SLOT_W-1:0]      slot_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    status_r;
  logic [SLOT_W-1:0]      oslot_r;
  logic [OFFSET_BITS-1:0] ooff_r;
  logic [SIZE_BITS-1:0]   osize_r;
  logic [REF_W-1:0]       oref_r;

  logic                   in_acc;
  logic [3:0]             n_c;
  logic [FP_W-1:0]        mask_c, key_c, tail_src;
  logic [31:0]            tail_c;

  logic                   b_we, b_re;
  logic [BKT_W-1:0]       b_waddr;
  logic [ROW_W-1:0]       b_wdata, b_rdata;
  logic                   e_we, e_re;
  logic [SLOT_W-1:0]      e_waddr, e_raddr;
  logic [ENT_W-1:0]       e_wdata, e_rdata;
  logic                   f_we;
  logic [SLOT_W-1:0]      f_waddr;
  logic [FH_W-1:0]        f_wdata, f_rdata;

  logic                   hit_c, emp_c;
  logic [WAY_W-1:0]       hit_way_c, emp_way_c;
  logic [SLOT_W-1:0]      ws;

  logic [OFFSET_BITS-1:0] e_off;
  logic [SIZE_BITS-1:0]   e_size;
  logic [REF_W-1:0]       e_ref;
  logic [SUM_W-1:0]       add_a, add_b, add_s;
  logic                   go;
  logic [STATUS_W-1:0]    st_c;
  logic [SLOT_W-1:0]      oslot_c;
  logic [OFFSET_BITS-1:0] ooff_c;
  logic [SIZE_BITS-1:0]   osize_c;
  logic [REF_W-1:0]       oref_c;
  logic                   fh_bad, no_space;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_log_slot    = oslot_r;
  assign out_data_offset = ooff_r;
  assign out_stored_size = osize_r;
  assign out_refcnt      = oref_r;

  always_comb begin
    n_c = nbytes_r;
    if (nbytes_r < 4'd4) n_c = 4'd4;
    if (nbytes_r > 4'd8) n_c = 4'd8;
    mask_c   = '1;
    tail_src = '0;
    unique case (n_c)
      4'd4:    mask_c = 64'h0000_0000_FFFF_FFFF;
      4'd5:    mask_c = 64'h0000_00FF_FFFF_FFFF;
      4'd6:    mask_c = 64'h0000_FFFF_FFFF_FFFF;
      4'd7:    mask_c = 64'h00FF_FFFF_FFFF_FFFF;
      default: mask_c = '1;
    endcase
    key_c = in_fingerprint & mask_c;
    unique case (n_c)
      4'd4:    tail_src = key_c;
      4'd5:    tail_src = key_c >> 8;
      4'd6:    tail_src = key_c >> 16;
      4'd7:    tail_src = key_c >> 24;
      default: tail_src = key_c >> 32;
    endcase
    tail_c = tail_src[31:0];
  end

  always_comb begin
    hit_c = 1'b0;
    emp_c = 1'b0;
    hit_way_c = '0;
    emp_way_c = '0;
    ws = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      ws = b_rdata[w*WAYF_W +: SLOT_W];
      if (ws != '0 && {1'b0, ws} < LE_CMP) begin
        if (!hit_c && (((b_rdata[w*WAYF_W+SLOT_W +: FP_W] ^ key_r) & mask_r) == '0)) begin
          hit_c = 1'b1;
          hit_way_c = WAY_W'(w);
        end
      end else if (!emp_c) begin
        emp_c = 1'b1;
        emp_way_c = WAY_W'(w);
      end
    end
  end

  assign e_raddr = hit_c ? b_rdata[hit_way_c*WAYF_W +: SLOT_W] : free_head_r[SLOT_W-1:0];
  assign {e_off, e_size, e_ref} = e_rdata;
  assign add_s  = add_a + add_b;
  assign fh_bad = (free_head_r == '0) || (free_head_r >= FH_LIM);
  assign no_space = (add_s[SUM_W-1:OFFSET_BITS] != '0);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    free_head_nxt = free_head_r;
    next_off_nxt  = next_off_r;
    out_valid_nxt = out_valid_r && out_stall;
    b_we = 1'b0; b_re = 1'b0; b_waddr = bkt_r; b_wdata = b_rdata;
    e_we = 1'b0; e_re = 1'b0; e_waddr = slot_r; e_wdata = e_rdata;
    f_we = 1'b0; f_waddr = slot_r; f_wdata = free_head_r;
    add_a = SUM_W'(e_ref);
    add_b = SUM_W'(1);
    go = 1'b0;
    st_c = ST_NOT_FOUND;
    oslot_c = '0; ooff_c = '0; osize_c = '0; oref_c = '0;
    unique case (state_r)
      S_CLEAR: begin
        b_we    = ({1'b0, clr_r} < NB_CMP);
        b_waddr = clr_r[BKT_W-1:0];
        b_wdata = '0;
        f_we    = ({1'b0, clr_r} < LE_CLR);
        f_waddr = clr_r[SLOT_W-1:0];
        f_wdata = FH_W'({1'b0, clr_r[SLOT_W-1:0]}) + FH_W'(1);
        clr_nxt = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        b_re = in_acc;
        if (in_acc) state_nxt = S_BKT;
      end
      S_BKT: begin
        e_re = 1'b1;
        state_nxt = S_ENT;
      end
      S_ENT: begin
        go = !(out_valid_r && out_stall);
        if (func_r == FUNC_NONE || (func_r != FUNC_WRITE && !hit_r)) begin
          st_c = ST_NOT_FOUND;
        end else if (hit_r) begin
          oslot_c = slot_r; ooff_c = e_off; osize_c = e_size; oref_c = e_ref;
          e_waddr = slot_r;
          if (func_r == FUNC_WRITE) begin
            st_c = ST_DUP;
            if (e_ref != REF_MAX) oref_c = add_s[REF_W-1:0];
            e_we = go;
            e_wdata = {e_off, e_size, oref_c};
          end else if (func_r == FUNC_READ) begin
            st_c = ST_FOUND;
          end else if (e_ref > REF_W'(1)) begin
            st_c = ST_DECR;
            add_b = '1;
            oref_c = add_s[REF_W-1:0];
            e_we = go;
            e_wdata = {e_off, e_size, oref_c};
          end else begin
            st_c = ST_FREED;
            oref_c = '0;
            e_we = go;
            e_wdata = {e_off, e_size, REF_W'(0)};
            b_we = go;
            b_wdata[hit_way_r*WAYF_W +: WAYF_W] = '0;
            f_we = go;
            f_waddr = slot_r;
            f_wdata = free_head_r;
            if (go) free_head_nxt = FH_W'({1'b0, slot_r});
          end
        end else begin
          add_a = SUM_W'(next_off_r);
          add_b = SUM_W'(csize_r);
          if (!emp_r) begin
            st_c = ST_BKT_FULL;
          end else if (fh_bad) begin
            st_c = ST_LOG_FULL;
          end else if (no_space) begin
            st_c = ST_NO_SPACE;
          end else begin
            st_c = ST_NEW;
            oslot_c = free_head_r[SLOT_W-1:0];
            ooff_c  = next_off_r;
            osize_c = SIZE_BITS'(csize_r);
            oref_c  = REF_W'(1);
            e_we    = go;
            e_waddr = free_head_r[SLOT_W-1:0];
            e_wdata = {next_off_r, SIZE_BITS'(csize_r), REF_W'(1)};
            b_we    = go;
            b_wdata[emp_way_r*WAYF_W +: WAYF_W] = {key_r, free_head_r[SLOT_W-1:0]};
            if (go) begin
              free_head_nxt = f_rdata;
              next_off_nxt  = add_s[OFFSET_BITS-1:0];
            end
          end
        end
        if (go) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nbytes_r    <= NBYTES_RESET;
      free_head_r <= FH_W'(1);
      next_off_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      next_off_r  <= next_off_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) nbytes_r <= cfg_fingerprint_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_func;
      key_r   <= key_c;
      mask_r  <= mask_c;
      csize_r <= in_chunk_size;
      bkt_r   <= tail_c[BKT_W-1:0];
    end
    if (state_r == S_BKT) begin
      hit_r     <= hit_c;
      emp_r     <= emp_c;
      hit_way_r <= hit_way_c;
      emp_way_r <= emp_way_c;
      slot_r    <= e_raddr;
    end
    if (go) begin
      status_r <= st_c;
      oslot_r  <= oslot_c;
      ooff_r   <= ooff_c;
      osize_r  <= osize_c;
      oref_r   <= oref_c;
    end
  end

  dfrt_ram #(.W(ROW_W), .D(NUM_BUCKETS)) u_bucket (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(tail_c[BKT_W-1:0]), .rdata(b_rdata)
  );

  dfrt_ram #(.W(ENT_W), .D(LOG_ENTRIES)) u_entry (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  dfrt_ram #(.W(FH_W), .D(LOG_ENTRIES)) u_free (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(f_rdata)
  );
endmodule

FILE: rtl/dfrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dfrt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: tb/sv/dedup_fingerprint_refcount_table_tb.sv
// Testbench for the dedup fingerprint refcount table: directed table, random traffic, checks.
module dedup_fingerprint_refcount_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfrt_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [11:0]        log_slot;
    logic [39:0]        data_offset;
    logic [19:0]        stored_size;
    logic [15:0]        refcnt;
  } chunk_result_t;

  typedef struct {
    func_t         func;
    logic [63:0]   fp;
    logic [19:0]   csize;
    bit            typed;
    chunk_result_t res;
  } table_row_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [63:0] in_fingerprint = '0;
  logic [19:0] in_chunk_size = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [3:0]  out_status;
  logic [11:0] out_log_slot;
  logic [39:0] out_data_offset;
  logic [19:0] out_stored_size;
  logic [15:0] out_refcnt;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [3:0]  cfg_fingerprint_bytes = '0;

  dedup_fingerprint_refcount_table dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] idx_keys [4096];
  logic [11:0] idx_slots [4096];
  logic [39:0] ent_offset [4096];
  logic [19:0] ent_size [4096];
  logic [15:0] ent_refs [4096];
  logic [12:0] free_link [4096];
  logic [12:0] free_top;
  logic [39:0] alloc_ptr;
  logic [3:0]  fp_bytes_reg;

  chunk_result_t pending_results [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int idle_cycles = 0;
  bit tx_gaps = 1;
  bit rx_gaps = 1;
  bit hold_req = 0;
  int rx_cnt = 0;

  function automatic chunk_result_t index_update(func_t f, logic [63:0] fp, logic [19:0] cs);
    int n, base, hit, empty;
    logic [63:0] mask, key;
    logic [31:0] tail;
    logic [11:0] s;
    chunk_result_t r;
    r = '{ST_NOT_FOUND, 0, 0, 0, 0};
    n = fp_bytes_reg < 4 ? 4 : (fp_bytes_reg > 8 ? 8 : fp_bytes_reg);
    mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 1);
    key = fp & mask;
    tail = 32'(key >> (8 * (n - 4)));
    base = (tail % NUM_BUCKETS) * BUCKET_WAYS;
    hit = -1;
    empty = -1;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (idx_slots[base + w] != 0) begin
        if (hit < 0 && ((idx_keys[base + w] ^ key) & mask) == 0) hit = w;
      end else if (empty < 0) begin
        empty = w;
      end
    end
    if (f == FUNC_NONE || (f != FUNC_WRITE && hit < 0)) return r;
    if (hit >= 0) begin
      s = idx_slots[base + hit];
      r.log_slot = s;
      r.data_offset = ent_offset[s];
      r.stored_size = ent_size[s];
      if (f == FUNC_WRITE) begin
        if (ent_refs[s] != 16'hFFFF) ent_refs[s]++;
        r.status = ST_DUP;
      end else if (f == FUNC_READ) begin
        r.status = ST_FOUND;
      end else if (ent_refs[s] > 1) begin
        ent_refs[s]--;
        r.status = ST_DECR;
      end else begin
        idx_slots[base + hit] = 0;
        ent_refs[s] = 0;
        free_link[s] = free_top;
        free_top = s;
        r.status = ST_FREED;
      end
      r.refcnt = ent_refs[s];
      return r;
    end
    if (empty < 0) begin
      r.status = ST_BKT_FULL;
      return r;
    end
    if (free_top == 0 || free_top >= LOG_ENTRIES) begin
      r.status = ST_LOG_FULL;
      return r;
    end
    if (64'(cs) > 64'hFF_FFFF_FFFF - 64'(alloc_ptr)) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    s = free_top[11:0];
    free_top = free_link[s];
    ent_offset[s] = alloc_ptr;
    ent_size[s] = cs;
    ent_refs[s] = 1;
    alloc_ptr = alloc_ptr + 40'(cs);
    idx_keys[base + empty] = key;
    idx_slots[base + empty] = s;
    r = '{ST_NEW, s, ent_offset[s], cs, 16'd1};
    return r;
  endfunction

  task automatic send_chunk(func_t f, logic [63:0] fp, logic [19:0] cs, bit typed,
                            chunk_result_t want, output chunk_result_t got);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_func = f;
    in_fingerprint = fp;
    in_chunk_size = cs;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    got = index_update(f, fp, cs);
    pending_results.push_back(typed ? want : got);
    n_items++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_fp_bytes(logic [3:0] v);
    drain();
    @(negedge clk);
    cfg_fingerprint_bytes = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    fp_bytes_reg = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      rx_cnt = 400;
    end
    if (rx_cnt > 0) begin
      out_stall = 1;
      rx_cnt--;
    end else begin
      out_stall = 0;
    end
  end

  always @(posedge clk) begin
    chunk_result_t e;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      rx_cnt = rx_gaps ? $urandom_range(0, 8) : 0;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, status %0d", out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors++;
        end
        if (out_log_slot !== e.log_slot) begin
          $error("log_slot expected %0d actual %0d", e.log_slot, out_log_slot);
          errors++;
        end
        if (out_data_offset !== e.data_offset) begin
          $error("data_offset expected %0h actual %0h", e.data_offset, out_data_offset);
          errors++;
        end
        if (out_stored_size !== e.stored_size) begin
          $error("stored_size expected %0h actual %0h", e.stored_size, out_stored_size);
          errors++;
        end
        if (out_refcnt !== e.refcnt) begin
          $error("refcnt expected %0d actual %0d", e.refcnt, out_refcnt);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] pool_key(int n, int bkt);
    logic [63:0] k;
    k = {$urandom, $urandom};
    k[8 * (n - 4) +: 10] = 10'(bkt);
    return k;
  endfunction

  initial begin
    table_row_t rows [$];
    chunk_result_t got, none;
    logic [63:0] keys [24];
    logic [3:0] settings [7];
    logic [63:0] k;
    func_t f;
    logic [19:0] cs;
    int n, r;

    none = '{ST_NOT_FOUND, 0, 0, 0, 0};
    settings = '{4'd6, 4'd4, 4'd8, 4'd0, 4'd15, 4'd5, 4'd7};
    fp_bytes_reg = NBYTES_RESET;
    free_top = 1;
    alloc_ptr = '0;
    for (int i = 0; i < 4096; i++) begin
      idx_slots[i] = 0;
      free_link[i] = 13'(i + 1);
    end

    repeat (8) @(negedge clk);
    rst_n = 1;

    rows.push_back('{FUNC_READ, 64'd0, 20'd0, 1, none});
    rows.push_back('{FUNC_WRITE, 64'd0, 20'd0, 1, '{ST_NEW, 1, 0, 0, 1}});
    rows.push_back('{FUNC_WRITE, '1, 20'hFFFFF, 1, '{ST_NEW, 2, 0, 20'hFFFFF, 1}});
    rows.push_back('{FUNC_WRITE, 64'd0, 20'd5, 1, '{ST_DUP, 1, 0, 0, 2}});
    rows.push_back('{FUNC_READ, 64'hFFFF_0000_0000_0000, 20'd9, 1, '{ST_FOUND, 1, 0, 0, 2}});
    rows.push_back('{FUNC_RELEASE, 64'd0, 20'd0, 1, '{ST_DECR, 1, 0, 0, 1}});
    rows.push_back('{FUNC_RELEASE, 64'd0, 20'd0, 1, '{ST_FREED, 1, 0, 0, 0}});
    rows.push_back('{FUNC_RELEASE, 64'd0, 20'd0, 1, none});
    rows.push_back('{FUNC_NONE, '1, 20'hFFFFF, 1, none});
    rows.push_back('{FUNC_WRITE, 64'd0, 20'd3, 0, none});
    for (int j = 1; j <= 4; j++)
      rows.push_back('{FUNC_WRITE, 64'h7_0000 | 64'(j), 20'(j), 0, none});
    rows.push_back('{FUNC_WRITE, 64'h7_0005, 20'd5, 1, '{ST_BKT_FULL, 0, 0, 0, 0}});
    rows.push_back('{FUNC_READ, 64'h7_0003, 20'd0, 0, none});
    rows.push_back('{FUNC_RELEASE, 64'h7_0002, 20'd0, 0, none});
    rows.push_back('{FUNC_WRITE, 64'h7_0005, 20'd1, 0, none});
    rows.push_back('{FUNC_READ, '1, 20'd0, 0, none});
    rows.push_back('{FUNC_RELEASE, '1, 20'd0, 0, none});
    foreach (rows[i])
      send_chunk(rows[i].func, rows[i].fp, rows[i].csize, rows[i].typed, rows[i].res, got);

    for (int p = 0; p < 7; p++) begin
      write_fp_bytes(settings[p]);
      n = settings[p] < 4 ? 4 : (settings[p] > 8 ? 8 : settings[p]);
      tx_gaps = (p % 3) != 2;
      rx_gaps = (p % 3) != 1;
      foreach (keys[i]) keys[i] = pool_key(n, $urandom_range(0, 5));
      if (p == 2) hold_req = 1;
      for (int i = 0; i < 260; i++) begin
        r = $urandom_range(0, 99);
        f = r < 45 ? FUNC_WRITE : (r < 65 ? FUNC_READ : (r < 95 ? FUNC_RELEASE : FUNC_NONE));
        k = $urandom_range(0, 6) == 0 ? {$urandom, $urandom} : keys[$urandom_range(0, 23)];
        if (n < 8 && $urandom_range(0, 3) == 0) k = k | ~((64'd1 << (8 * n)) - 64'd1);
        cs = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 20'hFFFFF : 20'd0) : 20'($urandom);
        send_chunk(f, k, cs, 0, none, got);
      end
      if (p == 4) drain();
    end

    drain();
    $display("covered %0d chunk transactions and %0d results under the reset key width",
             n_items, n_results);
    $display("and seven written ones, with full buckets, slot reuse and long output stalls");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
